// ===== rtl/sdivdw_pkg.sv =====
package sdivdw_pkg;

    localparam int unsigned OP_W      = 32;
    localparam int unsigned DIVD_W    = 2 * OP_W;
    localparam int unsigned HALF_W    = 16;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned DIV_STEPS = OP_W;
    localparam int unsigned S_DATA_W  = 96;
    localparam int unsigned S_USER_W  = 2;
    localparam int unsigned M_DATA_W  = 64;
    localparam int unsigned M_USER_W  = 1;

    typedef enum logic [1:0] {
        SIZE_BYTE  = 2'd0,
        SIZE_WORD  = 2'd1,
        SIZE_DWORD = 2'd2
    } size_mode_t;

    // sign-extended operands
    typedef struct packed {
        size_mode_t          size;
        logic [DIVD_W-1:0]   n;
        logic [OP_W-1:0]     d;
    } raw_t;

    // magnitudes and signs
    typedef struct packed {
        size_mode_t          size;
        logic [DIVD_W-1:0]   un;
        logic [OP_W-1:0]     ud;
        logic                nneg;
        logic                qneg;
        logic                zero;
    } mag_t;

    // one radix-2 step: partial remainder, dividend bits shifting out, quotient shifting in
    typedef struct packed {
        size_mode_t          size;
        logic [OP_W-1:0]     rem;
        logic [OP_W-1:0]     lq;
        logic [OP_W-1:0]     dsr;
        logic                nneg;
        logic                qneg;
        logic                err;
    } div_t;

    typedef struct packed {
        logic [OP_W-1:0]     quotient;
        logic [OP_W-1:0]     remainder;
        logic                divide_error;
    } res_t;

    function automatic div_t div_step(input div_t cur);
        div_t           nxt;
        logic [OP_W:0]  t;
        logic [OP_W:0]  diff;
        logic           qbit;
        nxt  = cur;
        t    = {cur.rem, cur.lq[OP_W-1]};
        diff = t - {1'b0, cur.dsr};
        qbit = (t >= {1'b0, cur.dsr});
        nxt.rem = qbit ? diff[OP_W-1:0] : t[OP_W-1:0];
        nxt.lq  = {cur.lq[OP_W-2:0], qbit};
        return nxt;
    endfunction

endpackage

// ===== rtl/signed_divide_double_width_top.sv =====
// signed double-width divide, x86 idiv style
// input channel s_axis: tuser carries the operand size (0 byte, 1 word, 2 dword,
// 3 treated as dword), tdata carries the dividend high half, the dividend low half
// and the divisor. byte mode divides the 16-bit low half by an 8-bit divisor, word
// mode divides dx:ax by 16 bits, dword mode divides edx:eax by 32 bits
// output channel m_axis: tdata carries quotient and remainder at operand width,
// zero-extended; tuser is the divide-error flag, set with zero results when the
// divisor is zero or the quotient does not fit the signed operand range
// throughput: one transaction per cycle while s_axis_tready is high; the divider is a chain of 32 radix-2
// stages, one quotient bit each, behind a sign-extend stage and a magnitude stage
// reset clears all valid bits; the pipeline comes out of reset empty and ready
// when the receiver stalls, a skid register takes the one result in flight;
// once it is full, s_axis_tready drops and the whole pipeline holds without loss
module signed_divide_double_width_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // dividend_high [31:0], dividend_low [63:32], divisor [95:64]
    input  logic [sdivdw_pkg::S_DATA_W-1:0] s_axis_tdata,
    // size_mode [1:0]
    input  logic [sdivdw_pkg::S_USER_W-1:0] s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // quotient [31:0], remainder [63:32]
    output logic [sdivdw_pkg::M_DATA_W-1:0] m_axis_tdata,
    // divide_error [0]
    output logic [sdivdw_pkg::M_USER_W-1:0] m_axis_tuser
);
    import sdivdw_pkg::*;

    logic [OP_W-1:0] in_hi;
    logic [OP_W-1:0] in_lo;
    logic [OP_W-1:0] in_dv;

    raw_t  raw_next;
    raw_t  raw_reg;
    logic  raw_vld_reg;
    mag_t  mag_next;
    mag_t  mag_reg;
    logic  mag_vld_reg;
    div_t  div_next [DIV_STEPS+1];
    div_t  div_reg  [DIV_STEPS+1];
    logic [DIV_STEPS:0] div_vld_reg;

    res_t            fin;
    logic            fin_vld;
    logic [OP_W-1:0] lim;
    logic [OP_W-1:0] wmask;
    logic [OP_W-1:0] uq;
    logic [OP_W-1:0] q_signed;
    logic [OP_W-1:0] r_signed;
    logic            q_ovf;

    res_t  out_reg;
    logic  out_vld_reg;
    res_t  skid_reg;
    logic  skid_vld_reg;
    logic  pipe_en;
    logic  out_load;

    assign pipe_en       = !skid_vld_reg;
    assign s_axis_tready = pipe_en;

    assign in_hi = s_axis_tdata[OP_W-1:0];
    assign in_lo = s_axis_tdata[2*OP_W-1:OP_W];
    assign in_dv = s_axis_tdata[3*OP_W-1:2*OP_W];

    // sign extension per operand size
    always_comb
    begin
        unique case (s_axis_tuser)
            SIZE_BYTE:
            begin
                raw_next.size = SIZE_BYTE;
                raw_next.n    = {{(DIVD_W-HALF_W){in_lo[HALF_W-1]}}, in_lo[HALF_W-1:0]};
                raw_next.d    = {{(OP_W-BYTE_W){in_dv[BYTE_W-1]}}, in_dv[BYTE_W-1:0]};
            end
            SIZE_WORD:
            begin
                raw_next.size = SIZE_WORD;
                raw_next.n    = {{OP_W{in_hi[HALF_W-1]}}, in_hi[HALF_W-1:0],
                                 in_lo[HALF_W-1:0]};
                raw_next.d    = {{(OP_W-HALF_W){in_dv[HALF_W-1]}}, in_dv[HALF_W-1:0]};
            end
            default:
            begin
                raw_next.size = SIZE_DWORD;
                raw_next.n    = {in_hi, in_lo};
                raw_next.d    = in_dv;
            end
        endcase
    end

    // magnitudes
    always_comb
    begin
        mag_next.size = raw_reg.size;
        mag_next.nneg = raw_reg.n[DIVD_W-1];
        mag_next.qneg = raw_reg.n[DIVD_W-1] ^ raw_reg.d[OP_W-1];
        mag_next.un   = raw_reg.n[DIVD_W-1] ? (~raw_reg.n + DIVD_W'(1)) : raw_reg.n;
        mag_next.ud   = raw_reg.d[OP_W-1] ? (~raw_reg.d + OP_W'(1)) : raw_reg.d;
        mag_next.zero = (raw_reg.d == '0);
    end

    // divider chain; high-half check catches quotients of 33 bits or more
    always_comb
    begin
        div_next[0].size = mag_reg.size;
        div_next[0].rem  = mag_reg.un[DIVD_W-1:OP_W];
        div_next[0].lq   = mag_reg.un[OP_W-1:0];
        div_next[0].dsr  = mag_reg.ud;
        div_next[0].nneg = mag_reg.nneg;
        div_next[0].qneg = mag_reg.qneg;
        div_next[0].err  = mag_reg.zero || (mag_reg.un[DIVD_W-1:OP_W] >= mag_reg.ud);
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            div_next[i+1] = div_step(div_reg[i]);
        end
    end

    // range check and sign fix-up
    always_comb
    begin
        unique case (div_reg[DIV_STEPS].size)
            SIZE_BYTE:
            begin
                lim   = OP_W'(1) << (BYTE_W - 1);
                wmask = OP_W'((64'd1 << BYTE_W) - 64'd1);
            end
            SIZE_WORD:
            begin
                lim   = OP_W'(1) << (HALF_W - 1);
                wmask = OP_W'((64'd1 << HALF_W) - 64'd1);
            end
            default:
            begin
                lim   = OP_W'(1) << (OP_W - 1);
                wmask = '1;
            end
        endcase
        uq       = div_reg[DIV_STEPS].lq;
        q_ovf    = div_reg[DIV_STEPS].qneg ? (uq > lim) : (uq >= lim);
        q_signed = div_reg[DIV_STEPS].qneg ? (~uq + OP_W'(1)) : uq;
        r_signed = div_reg[DIV_STEPS].nneg ? (~div_reg[DIV_STEPS].rem + OP_W'(1))
                                           : div_reg[DIV_STEPS].rem;
        fin.divide_error = div_reg[DIV_STEPS].err || q_ovf;
        fin.quotient     = fin.divide_error ? '0 : (q_signed & wmask);
        fin.remainder    = fin.divide_error ? '0 : (r_signed & wmask);
        fin_vld          = div_vld_reg[DIV_STEPS] && pipe_en;
    end

    assign out_load = !out_vld_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_vld_reg  <= 1'b0;
            mag_vld_reg  <= 1'b0;
            div_vld_reg  <= '0;
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            if (pipe_en)
            begin
                raw_vld_reg <= s_axis_tvalid;
                mag_vld_reg <= raw_vld_reg;
                div_vld_reg <= {div_vld_reg[DIV_STEPS-1:0], mag_vld_reg};
            end
            if (out_load)
            begin
                if (skid_vld_reg)
                begin
                    out_vld_reg  <= 1'b1;
                    skid_vld_reg <= 1'b0;
                end
                else
                begin
                    out_vld_reg <= fin_vld;
                end
            end
            else if (fin_vld)
            begin
                skid_vld_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            raw_reg <= raw_next;
            mag_reg <= mag_next;
            for (int i = 0; i <= DIV_STEPS; i++)
            begin
                div_reg[i] <= div_next[i];
            end
        end
        if (out_load)
        begin
            out_reg <= skid_vld_reg ? skid_reg : fin;
        end
        else if (fin_vld)
        begin
            skid_reg <= fin;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {out_reg.remainder, out_reg.quotient};
    assign m_axis_tuser  = out_reg.divide_error;

`ifndef SYNTH
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid holds a result while output register is empty");

    a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_vld_reg) |-> $past(out_vld_reg && !m_axis_tready))
        else $error("skid filled without an output stall");

    a_error_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("divide error with nonzero results");

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (div_vld_reg[DIV_STEPS] && !div_reg[DIV_STEPS].err)
            |-> (div_reg[DIV_STEPS].rem < div_reg[DIV_STEPS].dsr))
        else $error("final remainder not below divisor");
`endif

endmodule
